FILE: hw/rtl/source_sequence_gap_tracker_unit_assert.svh
// Assertion macros for the source sequence gap tracker.
// Used by the top level; relies on a clock and reset named clock and reset.
`ifndef SOURCE_SEQUENCE_GAP_TRACKER_UNIT_ASSERT_SVH
`define SOURCE_SEQUENCE_GAP_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define SGT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define SGT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sgt_pkg.sv
// Package for the source sequence gap tracker: sizes, result codes and
// transaction types. No dependencies.
`default_nettype none
package sgt_pkg;

   localparam int SRC_ENTRIES  = 128;
   localparam int SRC_IDX_W    = $clog2(SRC_ENTRIES);
   localparam int RULE_ENTRIES = 128;
   localparam int RULE_IDX_W   = $clog2(RULE_ENTRIES);
   localparam int GAP_LIMIT    = 64;
   localparam int GAP_CNT_W    = $clog2(GAP_LIMIT + 1);
   localparam int MAP_BITS     = 256;

   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_DENIED = 3'd1;
   localparam logic [2:0] KIND_DUP    = 3'd2;
   localparam logic [2:0] KIND_RESEND = 3'd3;
   localparam logic [2:0] KIND_RULE   = 3'd4;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_RULE   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] host_addr;
      logic [15:0] src_port;
      logic [7:0]  packet_no;
      logic [7:0]  former_no;
      logic [6:0]  rule_index;
      logic        rule_allow;
   } sgt_req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [7:0] resend_no;
      logic       table_flushed;
      logic       last;
   } sgt_rsp_type;

   typedef struct packed {
      logic        allow;
      logic [31:0] addr;
   } sgt_rule_type;

   // Search key broadcast to every cell
   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
   } sgt_key_type;

   // Write controls broadcast to every cell
   typedef struct packed {
      logic       flush;
      logic [7:0] last;
   } sgt_cell_wr_type;

   // Status a cell reports while it holds the search token
   typedef struct packed {
      logic       stop;
      logic       found;
      logic [7:0] last;
   } sgt_cell_out_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/sgt_cell.sv
// One source table cell: address, port and last packet number of one source,
// plus the search token stage. Depends on sgt_pkg.
`default_nettype none
module sgt_cell import sgt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             tok_in,
   input  wire logic             wr_sel,
   input  wire sgt_key_type      key,
   input  wire sgt_cell_wr_type  wr,
   output logic                  tok_out,
   output sgt_cell_out_type      status
);

   logic        tok_ff;
   logic [31:0] addr_ff;
   logic [15:0] port_ff;
   logic [7:0]  last_ff;
   logic        empty;
   logic        match;

   // hold the entry; a write beats a flush
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= 1'b0;
         addr_ff <= '0;
         port_ff <= '0;
         last_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         if (wr_sel) begin
            addr_ff <= key.addr;
            port_ff <= key.port;
            last_ff <= wr.last;
         end else if (wr.flush) begin
            addr_ff <= '0;
         end
      end
   end

   // stop the token on an empty entry or a match, else pass it on
   assign empty        = (addr_ff == '0);
   assign match        = (addr_ff == key.addr) && (port_ff == key.port);
   assign status.stop  = tok_ff & (empty | match);
   assign status.found = tok_ff & ~empty & match;
   assign status.last  = status.found ? last_ff : '0;
   assign tok_out      = tok_ff & ~empty & ~match;

endmodule
`default_nettype wire

FILE: hw/rtl/source_sequence_gap_tracker_unit.sv
// Top level of the source sequence gap tracker.
// Depends on sgt_pkg, sgt_cell, sgt_ram and the assertion macro header.
`default_nettype none
// Usage:
//   Input: drive req_data and raise start; the transaction is taken on a
//   clock edge where start is high and busy is low.
//   Output: each result appears for one cycle with rsp_valid high; the
//   receiver cannot stall, so results are never held back. The final result
//   of a transaction has last set.
//   Config: csr_data writes rule_count when csr_valid is high (csr_ready is
//   always high); write it only while busy is low.
//   Rule write: answers the next cycle and leaves busy low.
//   A packet stays busy through any rule scan up to the deciding rule (the
//   scan first waits on the rule memory read), then while the search token
//   walks the chain of 128 source cells up to the cell where it stops, then
//   to load the received-map row, then for one resend request per cycle
//   (below 64), and then for a final state. Each result shows in the cycle
//   after the state that makes it.
//   Reset: rules count zero, source cells empty, map rows read as clear;
//   no clearing pass is needed.
module source_sequence_gap_tracker_unit import sgt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire sgt_req_type req_data,
   output logic             rsp_valid,
   output sgt_rsp_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RULE   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_GAP    = 3'd4;
   localparam logic [2:0] ST_FINAL  = 3'd5;

   logic [2:0]           state_ff, state_in;
   sgt_req_type          req_ff, req_in;
   logic [7:0]           rule_count_ff, rule_count_in;
   logic [7:0]           rule_rd_ff, rule_rd_in;
   logic [7:0]           rule_chk_ff, rule_chk_in;
   logic                 rule_pend_ff, rule_pend_in;
   logic [SRC_IDX_W-1:0] srch_idx_ff, srch_idx_in;
   logic [SRC_IDX_W-1:0] ent_ff, ent_in;
   logic                 found_ff, found_in;
   logic                 flushed_ff, flushed_in;
   logic [7:0]           last_no_ff, last_no_in;
   logic [MAP_BITS-1:0]  row_ff, row_in;
   logic [7:0]           gap_no_ff, gap_no_in;
   logic [GAP_CNT_W-1:0] gap_cnt_ff, gap_cnt_in;
   logic [SRC_ENTRIES-1:0] map_vld_ff, map_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sgt_rsp_type          rsp_ff, rsp_in;

   logic                 accept;
   logic [7:0]           nrules;
   logic [7:0]           nrules_m1;
   logic                 rule_we;
   sgt_rule_type         rule_wdata;
   sgt_rule_type         rule_rdata;
   logic                 map_we;
   logic [SRC_IDX_W-1:0] map_raddr;
   logic [MAP_BITS-1:0]  map_rdata;
   logic [MAP_BITS-1:0]  row_base;
   logic [7:0]           gap_next;
   logic [7:0]           gap_dist;
   logic                 search_go;
   logic                 cell_we;
   logic [SRC_IDX_W-1:0] cell_idx;
   logic                 cell_flush;
   logic [SRC_ENTRIES-1:0] cell_sel;
   logic [SRC_ENTRIES:0] tok;
   logic                 tok_exit;
   sgt_cell_out_type     cell_st [SRC_ENTRIES];
   logic [SRC_ENTRIES-1:0] stop_vec;
   logic                 any_stop;
   logic                 any_found;
   logic [7:0]           sel_last;
   sgt_key_type          key;
   sgt_cell_wr_type      cell_wr;
   logic                 is_dup;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign nrules    = (rule_count_ff > 8'(RULE_ENTRIES)) ? 8'(RULE_ENTRIES) : rule_count_ff;
   assign nrules_m1 = nrules - 8'd1;

   // rule memory: written directly from an accepted rule transaction
   assign rule_we          = accept && (req_data.operation == OP_RULE);
   assign rule_wdata.allow = req_data.rule_allow;
   assign rule_wdata.addr  = req_data.host_addr;

   sgt_ram #(
      .WIDTH ($bits(sgt_rule_type)),
      .DEPTH (RULE_ENTRIES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (req_data.rule_index[RULE_IDX_W-1:0]),
      .wr_data (rule_wdata),
      .rd_addr (rule_rd_ff[RULE_IDX_W-1:0]),
      .rd_data (rule_rdata)
   );

   // received-map rows, one per source entry
   sgt_ram #(
      .WIDTH (MAP_BITS),
      .DEPTH (SRC_ENTRIES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (ent_ff),
      .wr_data (row_ff),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // chain of source cells; the token enters at cell zero
   assign key.addr     = req_ff.host_addr;
   assign key.port     = req_ff.src_port;
   assign cell_wr.flush = cell_flush;
   assign cell_wr.last  = req_ff.packet_no;
   assign tok[0]       = search_go;
   assign tok_exit     = tok[SRC_ENTRIES];

   for (genvar gi = 0; gi < SRC_ENTRIES; gi++) begin : g_cell
      sgt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[gi]),
         .wr_sel  (cell_sel[gi]),
         .key     (key),
         .wr      (cell_wr),
         .tok_out (tok[gi+1]),
         .status  (cell_st[gi])
      );
   end

   // collect the one cell that holds the token and stopped
   always_comb begin
      any_stop  = 1'b0;
      any_found = 1'b0;
      sel_last  = '0;
      for (int i = 0; i < SRC_ENTRIES; i++) begin
         stop_vec[i] = cell_st[i].stop;
         any_stop    = any_stop | cell_st[i].stop;
         any_found   = any_found | cell_st[i].found;
         sel_last    = sel_last | cell_st[i].last;
         cell_sel[i] = cell_we && (cell_idx == SRC_IDX_W'(i));
      end
   end

   // map row as loaded: unwritten rows read clear, then mark this packet
   always_comb begin
      row_base = map_vld_ff[ent_ff] ? map_rdata : '0;
      row_base[req_ff.packet_no] = 1'b1;
   end

   assign gap_next = last_no_ff + 8'd1;
   assign gap_dist = req_ff.packet_no - gap_next;
   assign is_dup   = (req_ff.packet_no != req_ff.former_no) && row_ff[req_ff.former_no];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rule_count_in = rule_count_ff;
      rule_rd_in    = rule_rd_ff;
      rule_chk_in   = rule_chk_ff;
      rule_pend_in  = rule_pend_ff;
      srch_idx_in   = srch_idx_ff;
      ent_in        = ent_ff;
      found_in      = found_ff;
      flushed_in    = flushed_ff;
      last_no_in    = last_no_ff;
      row_in        = row_ff;
      gap_no_in     = gap_no_ff;
      gap_cnt_in    = gap_cnt_ff;
      map_vld_in    = map_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      map_we        = 1'b0;
      map_raddr     = ent_ff;
      search_go     = 1'b0;
      cell_we       = 1'b0;
      cell_idx      = ent_ff;
      cell_flush    = 1'b0;

      if (csr_valid) begin
         rule_count_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               rule_rd_in   = '0;
               rule_pend_in = 1'b0;
               if (req_data.operation == OP_RULE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_RULE, 8'd0, 1'b0, 1'b1};
               end else if (nrules == '0) begin
                  search_go   = 1'b1;
                  srch_idx_in = '0;
                  state_in    = ST_SEARCH;
               end else begin
                  state_in = ST_RULE;
               end
            end
         end
         ST_RULE: begin
            // advance the read pointer; check the word that came back
            rule_rd_in   = rule_rd_ff + 8'd1;
            rule_chk_in  = rule_rd_ff;
            rule_pend_in = (rule_rd_ff < nrules);
            if (rule_pend_ff &&
                ((rule_chk_ff == nrules_m1) || (rule_rdata.addr == req_ff.host_addr))) begin
               if (rule_rdata.allow) begin
                  search_go   = 1'b1;
                  srch_idx_in = '0;
                  state_in    = ST_SEARCH;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{KIND_DENIED, 8'd0, 1'b0, 1'b1};
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_SEARCH: begin
            srch_idx_in = srch_idx_ff + SRC_IDX_W'(1);
            if (any_stop || tok_exit) begin
               ent_in     = tok_exit ? '0 : srch_idx_ff;
               found_in   = any_found;
               flushed_in = tok_exit;
               last_no_in = sel_last;
               cell_we    = 1'b1;
               cell_idx   = ent_in;
               cell_flush = tok_exit;
               map_raddr  = ent_in;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            row_in     = row_base;
            gap_no_in  = gap_next;
            gap_cnt_in = gap_dist[GAP_CNT_W-1:0];
            if (found_ff && (gap_dist != '0) && (gap_dist < 8'(GAP_LIMIT))) begin
               state_in = ST_GAP;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_GAP: begin
            // request one missing number and drop its bit
            row_in[gap_no_ff] = 1'b0;
            rsp_valid_in      = 1'b1;
            rsp_in            = '{KIND_RESEND, gap_no_ff, 1'b0, 1'b0};
            gap_no_in         = gap_no_ff + 8'd1;
            gap_cnt_in        = gap_cnt_ff - GAP_CNT_W'(1);
            if (gap_cnt_ff == GAP_CNT_W'(1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            map_we             = 1'b1;
            map_vld_in[ent_ff] = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_in             = '{(is_dup ? KIND_DUP : KIND_ACCEPT), 8'd0, flushed_ff, 1'b1};
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rule_count_ff <= '0;
         rule_pend_ff  <= 1'b0;
         map_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rule_count_ff <= rule_count_in;
         rule_pend_ff  <= rule_pend_in;
         map_vld_ff    <= map_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rule_rd_ff  <= rule_rd_in;
      rule_chk_ff <= rule_chk_in;
      srch_idx_ff <= srch_idx_in;
      ent_ff      <= ent_in;
      found_ff    <= found_in;
      flushed_ff  <= flushed_in;
      last_no_ff  <= last_no_in;
      row_ff      <= row_in;
      gap_no_ff   <= gap_no_in;
      gap_cnt_ff  <= gap_cnt_in;
      rsp_ff      <= rsp_in;
   end

`include "source_sequence_gap_tracker_unit_assert.svh"

   `SGT_ASSERT_NOW(a_one_stop, 1'b1, $onehot0(stop_vec), "more than one cell stopped the token")
   `SGT_ASSERT_NEXT(a_gap_emits, state_ff == ST_GAP, rsp_valid, "gap cycle gave no request")
   `SGT_ASSERT_NEXT(a_final_idle, state_ff == ST_FINAL, !busy && rsp_valid && rsp_data.last, "final cycle did not close the transaction")
   `SGT_ASSERT_NOW(a_resend_shape, rsp_valid && (rsp_data.result_kind == KIND_RESEND), !rsp_data.last && !rsp_data.table_flushed, "malformed resend request")

endmodule
`default_nettype wire

FILE: test/source_sequence_gap_tracker_unit_tb.sv
// Testbench for the source sequence gap tracker: drives packet and rule
// transactions, predicts every result and checks them in order.
// Depends on sgt_pkg and source_sequence_gap_tracker_unit.
`timescale 1ns / 1ps
module source_sequence_gap_tracker_unit_tb;
   import sgt_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int POOL_SIZE   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   sgt_req_type req_data = '0;
   logic        rsp_valid;
   sgt_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   source_sequence_gap_tracker_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted copy of the block's state
   logic         rule_allow_q [RULE_ENTRIES];
   logic [31:0]  rule_addr_q [RULE_ENTRIES];
   logic [31:0]  src_addr_q [SRC_ENTRIES];
   logic [15:0]  src_port_q [SRC_ENTRIES];
   logic [7:0]   src_last_q [SRC_ENTRIES];
   logic [255:0] seen_map_q [SRC_ENTRIES];
   int unsigned  rules_in_use = 0;

   sgt_req_type  pending_items[$];
   sgt_rsp_type  expected_rsps[$];
   int unsigned  error_count = 0;
   bit           hold_sender = 1'b0;

   // Stimulus-side bookkeeping
   bit           slot_written [RULE_ENTRIES];
   logic [31:0]  pool_addr [POOL_SIZE];
   logic [15:0]  pool_port [POOL_SIZE];
   logic [7:0]   pool_next [POOL_SIZE];

   function automatic sgt_rsp_type make_rsp(logic [2:0] kind, logic [7:0] no,
                                            logic fl, logic fin);
      sgt_rsp_type r;
      r.result_kind   = kind;
      r.resend_no     = no;
      r.table_flushed = fl;
      r.last          = fin;
      return r;
   endfunction

   // Compute and queue the results of one accepted transaction
   task automatic predict_results(sgt_req_type t);
      int unsigned nr, i, e, k;
      bit found, flushed, hit;
      logic [7:0] next;
      found = 0;
      flushed = 0;
      k = 0;
      if (t.operation == OP_RULE) begin
         rule_allow_q[t.rule_index] = t.rule_allow;
         rule_addr_q[t.rule_index]  = t.host_addr;
         expected_rsps.push_back(make_rsp(KIND_RULE, 8'd0, 1'b0, 1'b1));
         return;
      end
      nr = (rules_in_use < RULE_ENTRIES) ? rules_in_use : RULE_ENTRIES;
      for (i = 0; i < nr; i++) begin
         hit = (i + 1 == nr) || (rule_addr_q[i] == t.host_addr);
         if (hit) begin
            if (rule_allow_q[i]) break;
            expected_rsps.push_back(make_rsp(KIND_DENIED, 8'd0, 1'b0, 1'b1));
            return;
         end
      end
      for (e = 0; e < SRC_ENTRIES; e++) begin
         if (src_addr_q[e] == 0) break;
         if (src_addr_q[e] == t.host_addr && src_port_q[e] == t.src_port) begin
            found = 1;
            break;
         end
      end
      if (found) begin
         next = src_last_q[e] + 8'd1;
         src_last_q[e] = t.packet_no;
         seen_map_q[e][t.packet_no] = 1'b1;
         if (t.packet_no != next && 8'(t.packet_no - next) < GAP_LIMIT) begin
            while (next != t.packet_no && k < GAP_LIMIT) begin
               expected_rsps.push_back(make_rsp(KIND_RESEND, next, 1'b0, 1'b0));
               k++;
               seen_map_q[e][next] = 1'b0;
               next = next + 8'd1;
            end
         end
      end else begin
         if (e >= SRC_ENTRIES) begin
            for (i = 0; i < SRC_ENTRIES; i++) src_addr_q[i] = '0;
            flushed = 1;
            e = 0;
         end
         src_addr_q[e] = t.host_addr;
         src_port_q[e] = t.src_port;
         src_last_q[e] = t.packet_no;
         seen_map_q[e][t.packet_no] = 1'b1;
      end
      if (t.packet_no != t.former_no && seen_map_q[e][t.former_no])
         expected_rsps.push_back(make_rsp(KIND_DUP, 8'd0, flushed, 1'b1));
      else
         expected_rsps.push_back(make_rsp(KIND_ACCEPT, 8'd0, flushed, 1'b1));
   endtask

   task automatic report_mismatch(string what, sgt_rsp_type got, sgt_rsp_type want);
      error_count++;
      $display("MISMATCH %s: got kind=%0d no=%0d fl=%0d last=%0d, want kind=%0d no=%0d fl=%0d last=%0d",
               what, got.result_kind, got.resend_no, got.table_flushed, got.last,
               want.result_kind, want.resend_no, want.table_flushed, want.last);
   endtask

   // Driver: feed queued transactions in bursts with random gaps
   int unsigned burst_left = 4;
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      bit accepted;
      bit drive_start;
      sgt_req_type nxt;
      accepted = start && !busy;
      drive_start = 1'b0;
      nxt = req_data;
      if (!reset && accepted) predict_results(req_data);
      if (reset) begin
         drive_start = 1'b0;
      end else if (start && !accepted) begin
         drive_start = 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (!hold_sender && pending_items.size() > 0) begin
         nxt = pending_items.pop_front();
         drive_start = 1'b1;
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         end
      end
      start <= drive_start;
      req_data <= nxt;
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      sgt_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", rsp_data, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_kind !== want.result_kind)
               report_mismatch("result_kind", rsp_data, want);
            else if (rsp_data.resend_no !== want.resend_no)
               report_mismatch("resend_no", rsp_data, want);
            else if (rsp_data.table_flushed !== want.table_flushed)
               report_mismatch("table_flushed", rsp_data, want);
            else if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data, want);
         end
      end
   end

   // Watchdog
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic sgt_req_type rule_item(int unsigned idx, logic [31:0] addr,
                                             logic allow);
      sgt_req_type t;
      t = sgt_req_type'({$urandom, $urandom, $urandom});
      t.operation  = OP_RULE;
      t.rule_index = idx[6:0];
      t.host_addr  = addr;
      t.rule_allow = allow;
      slot_written[idx] = 1'b1;
      return t;
   endfunction

   function automatic sgt_req_type packet_item(logic [31:0] addr, logic [15:0] port,
                                               logic [7:0] pn, logic [7:0] pnf);
      sgt_req_type t;
      t = sgt_req_type'({$urandom, $urandom, $urandom});
      t.operation = OP_PACKET;
      t.host_addr = addr;
      t.src_port  = port;
      t.packet_no = pn;
      t.former_no = pnf;
      return t;
   endfunction

   // Packet, mostly from a pool source; style picks in-order, gap, resend or noise
   function automatic sgt_req_type random_packet();
      int unsigned s, pick;
      logic [7:0] pn, pnf;
      s = $urandom_range(0, POOL_SIZE - 1);
      pick = $urandom_range(0, 99);
      pn = pool_next[s];
      pnf = pn;
      if (pick >= 55 && pick < 72) begin
         pn = pool_next[s] + 8'($urandom_range(1, 70));
         pnf = pn;
      end else if (pick >= 72 && pick < 88) begin
         pnf = pool_next[s] - 8'($urandom_range(1, 80));
      end else if (pick >= 88) begin
         pn = 8'($urandom);
         pnf = ($urandom_range(0, 1) == 1) ? pn : 8'($urandom);
      end
      pool_next[s] = pn + 8'd1;
      if (pick >= 95) return packet_item($urandom, 16'($urandom), pn, pnf);
      return packet_item(pool_addr[s], pool_port[s], pn, pnf);
   endfunction

   // Wait until everything queued has been answered and the block is idle;
   // sample on the falling edge so the driver's updates have settled
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() > 0 || start || expected_rsps.size() > 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // Write rule_count after making sure every slot in use has been written
   task automatic set_rule_count(int unsigned value);
      int unsigned i, used;
      used = (value < RULE_ENTRIES) ? value : RULE_ENTRIES;
      for (i = 0; i < used; i++)
         if (!slot_written[i])
            pending_items.push_back(rule_item(i, $urandom,
                                              $urandom_range(0, 3) != 0));
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value[7:0];
      do @(posedge clock);
      while (!csr_ready);
      rules_in_use = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            pending_items.push_back(rule_item($urandom_range(0, RULE_ENTRIES - 1),
               ($urandom_range(0, 1) == 1) ? pool_addr[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom,
               $urandom_range(0, 3) != 0));
         else
            pending_items.push_back(random_packet());
      end
   endtask

   initial begin
      int unsigned i;
      for (i = 0; i < SRC_ENTRIES; i++) begin
         src_addr_q[i] = '0;
         src_port_q[i] = '0;
         src_last_q[i] = '0;
         seen_map_q[i] = '0;
      end
      for (i = 0; i < RULE_ENTRIES; i++) slot_written[i] = 1'b0;
      for (i = 0; i < POOL_SIZE; i++) begin
         pool_addr[i] = $urandom;
         pool_port[i] = 16'($urandom);
         pool_next[i] = 8'($urandom);
      end
      pool_addr[0] = 32'h0;
      pool_addr[1] = 32'hFFFF_FFFF;
      pool_port[1] = 16'hFFFF;
      pool_port[2] = 16'h0000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: rules, then filtering, gaps, resends, wrap and address zero
      pending_items.push_back(rule_item(0, pool_addr[3], 1'b0));
      pending_items.push_back(rule_item(1, pool_addr[4], 1'b1));
      pending_items.push_back(rule_item(2, 32'h0, 1'b1));
      pending_items.push_back(rule_item(RULE_ENTRIES - 1, 32'hFFFF_FFFF, 1'b0));
      pending_items.push_back(packet_item(pool_addr[1], 16'hFFFF, 8'd255, 8'd255));
      set_rule_count(3);
      pending_items.push_back(packet_item(pool_addr[3], 16'd7, 8'd1, 8'd1));
      pending_items.push_back(packet_item(pool_addr[4], 16'd7, 8'd1, 8'd1));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd254, 8'd254));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd255));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd0, 8'd0));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd64, 8'd64));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd65, 8'd3));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd66, 8'd64));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd131, 8'd131));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd100, 8'd100));
      pending_items.push_back(packet_item(32'h0, 16'h0, 8'd5, 8'd5));
      pending_items.push_back(packet_item(32'h0, 16'h0, 8'd9, 8'd5));
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'h0000, 8'd0, 8'hFF));
      drain();

      // Hold the sender with a packet queued, then release it
      hold_sender = 1'b1;
      pending_items.push_back(packet_item(32'hFFFF_FFFF, 16'hFFFF, 8'd101, 8'd101));
      repeat (50) @(posedge clock);
      hold_sender = 1'b0;

      // Overflow the source table with fresh sources, filtering off
      set_rule_count(0);
      for (i = 0; i < SRC_ENTRIES + 4; i++)
         pending_items.push_back(packet_item({1'b1, 31'(i)} ^ 32'h5A5A_0000,
                                             16'($urandom), 8'($urandom), 8'($urandom)));
      drain();

      // Random traffic over a few rule counts
      set_rule_count(1);
      random_phase(25);
      set_rule_count($urandom_range(2, 12));
      random_phase(35);
      drain();

      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sgt_pkg.sv
hw/rtl/sgt_ram.sv
hw/rtl/sgt_cell.sv
hw/rtl/source_sequence_gap_tracker_unit.sv
test/source_sequence_gap_tracker_unit_tb.sv
